// ----- design/prc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline rectangle clipper package
// Word types, register indexes and command types shared by the clipper files.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgClipLeft   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgClipTop    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgClipWidth  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgClipHeight = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgShiftX     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgShiftY     = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgZoom       = 3'd6;

  localparam logic [CfgDataWidth-1:0] ZoomReset = 16'd256;
  localparam int unsigned ZoomFracBits = 8;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               new_line;
  } prc_in_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } prc_out_t;

  typedef struct packed {
    logic mul;
    logic div;
  } prc_cmd_t;

endpackage

// ----- design/prc_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply and divide unit
// One registered multiplier followed by a restoring divider that retires one
// quotient bit per cycle and rounds to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module prc_muldiv #(
  parameter int unsigned MagWidth = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  prc_pkg::prc_cmd_t       cmd_i,
  input  logic [MagWidth-1:0]     opa_i,
  input  logic [MagWidth-1:0]     opb_i,
  input  logic [MagWidth-1:0]     den_i,
  output logic [2*MagWidth-1:0]   prod_o,
  output logic [MagWidth-1:0]     quot_o,
  output logic                    done_o
);
  import prc_pkg::*;

  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  logic [2*MagWidth-1:0] prod_q;
  logic [2*MagWidth-1:0] mul_res;
  logic [MagWidth-1:0]   rem_q;
  logic [MagWidth-1:0]   lo_q;
  logic [MagWidth-1:0]   quo_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [MagWidth:0]     trial;
  logic                  step_bit;
  logic [MagWidth-1:0]   step_rem;
  logic                  round_up;

  assign mul_res  = opa_i * opb_i;
  assign trial    = {rem_q, lo_q[MagWidth-1]};
  assign step_bit = trial >= {1'b0, den_i};
  assign step_rem = step_bit ? MagWidth'(trial - {1'b0, den_i}) : trial[MagWidth-1:0];
  assign round_up = {rem_q, 1'b0} >= {1'b0, den_i};

  assign prod_o = prod_q;
  assign quot_o = quo_q + MagWidth'(round_up);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      rem_q  <= '0;
      lo_q   <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.mul) begin
        prod_q <= mul_res;
      end
      if (cmd_i.div) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(MagWidth);
        rem_q  <= prod_q[2*MagWidth-1:MagWidth];
        lo_q   <= prod_q[MagWidth-1:0];
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= step_rem;
        lo_q  <= {lo_q[MagWidth-2:0], 1'b0};
        quo_q <= {quo_q[MagWidth-2:0], step_bit};
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient fits the magnitude width, so the partial remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> rem_q < den_i)
    else $error("remainder reached the divisor during division");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("division finished without running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !cmd_i.mul)
    else $error("product overwritten during division");

endmodule

// ----- design/polyline_rect_clipper.sv -----
`timescale 1ns / 1ps
// A vertex that opens a polyline is taken while idle and gives no word. Each
// crossed edge of a segment adds a multiply and a division on the bit-serial
// divider of the shared unit.
// One vertex is worked on at a time; the input stalls until its segment is done.
// Reset clears the previous vertex and sets the registers to their reset values.
// ----------------------------------------------------------------------------
// Polyline rectangle clipper
// Clips polyline segments against a rectangle edge by edge, then scales and
// offsets the visible segment, using one shared multiply and divide unit.
// ----------------------------------------------------------------------------
module polyline_rect_clipper #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [prc_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  prc_pkg::prc_in_t                    in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output prc_pkg::prc_out_t                   out_word_o
);
  import prc_pkg::*;

  localparam int unsigned CW = FRACTION_BITS + 16;
  localparam int unsigned MW = CW;
  localparam int unsigned EW = FRACTION_BITS + 18;
  localparam int unsigned DW = FRACTION_BITS + 19;
  localparam int unsigned SW = 2 * MW + 1;
  localparam int unsigned RW = 2 * MW + 3;
  localparam logic signed [RW-1:0] SatHi = {{(RW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RW-1:0] SatLo = {{(RW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [RW-1:0] RoundBias = RW'(1 << (ZoomFracBits - 1));

  typedef enum logic [3:0] {
    SIdle, SEdge, SMul, SDivStart, SDivWait, SFix, SScaleMul, SScaleAdd, SPush
  } state_e;

  typedef enum logic [1:0] {EdgeLeft, EdgeRight, EdgeTop, EdgeBottom} edge_e;

  state_e state_q;
  edge_e  edge_q;
  logic [1:0] sidx_q;

  logic signed [15:0] clip_left_q, clip_top_q, shift_x_q, shift_y_q;
  logic [15:0] clip_width_q, clip_height_q, zoom_q;

  logic signed [15:0] prior_x_q, prior_y_q;
  logic prior_valid_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [31:0] res_q [4];
  logic out_valid_q;
  prc_out_t out_q;

  logic edge_is_x, inside_hi;
  logic signed [17:0] x_lo, x_hi, y_lo, y_hi, edge_pos18;
  logic signed [EW-1:0] edge_pos;
  logic signed [CW-1:0] a_perp, b_perp, a_par, b_par;
  logic signed [DW-1:0] d0, d1;
  logic d0_pos, d0_neg, d1_pos, d1_neg, drop, pass;
  logic signed [CW:0] delta, dperp;
  logic [MW-1:0] mag_delta, mag_d0, den;
  logic signed [CW:0] p_par_wide;
  logic signed [CW-1:0] p_par, p_perp;
  logic signed [CW-1:0] p_sel;
  logic [MW-1:0] mag_p;
  logic signed [15:0] shift_sel;
  logic scaling;
  logic signed [SW-1:0] sprod;
  logic signed [RW-1:0] rnd, scaled;
  logic signed [31:0] sat_val;

  prc_cmd_t cmd;
  logic [MW-1:0] opa, opb;
  logic [2*MW-1:0] prod;
  logic [MW-1:0] quot;
  logic div_done;

  always_comb begin
    edge_is_x = (edge_q == EdgeLeft) || (edge_q == EdgeRight);
    inside_hi = (edge_q == EdgeLeft) || (edge_q == EdgeTop);
    x_lo = 18'(clip_left_q);
    x_hi = x_lo + 18'(clip_width_q);
    y_lo = 18'(clip_top_q);
    y_hi = y_lo + 18'(clip_height_q);
    unique case (edge_q)
      EdgeLeft:   edge_pos18 = x_lo;
      EdgeRight:  edge_pos18 = x_hi;
      EdgeTop:    edge_pos18 = y_lo;
      EdgeBottom: edge_pos18 = y_hi;
      default:    edge_pos18 = x_lo;
    endcase
    edge_pos = {edge_pos18, {FRACTION_BITS{1'b0}}};

    a_perp = edge_is_x ? ax_q : ay_q;
    b_perp = edge_is_x ? bx_q : by_q;
    a_par  = edge_is_x ? ay_q : ax_q;
    b_par  = edge_is_x ? by_q : bx_q;

    d0 = inside_hi ? DW'(a_perp) - DW'(edge_pos) : DW'(edge_pos) - DW'(a_perp);
    d1 = inside_hi ? DW'(b_perp) - DW'(edge_pos) : DW'(edge_pos) - DW'(b_perp);
    d0_neg = d0[DW-1];
    d1_neg = d1[DW-1];
    d0_pos = !d0_neg && (d0 != '0);
    d1_pos = !d1_neg && (d1 != '0);
    drop = !d0_pos && !d1_pos;
    pass = !d0_neg && !d1_neg;

    delta = (CW+1)'(b_par) - (CW+1)'(a_par);
    dperp = (CW+1)'(a_perp) - (CW+1)'(b_perp);
    mag_delta = delta[CW] ? MW'(-delta) : MW'(delta);
    den = dperp[CW] ? MW'(-dperp) : MW'(dperp);
    mag_d0 = d0_neg ? MW'(-d0) : MW'(d0);

    p_par_wide = delta[CW] ? (CW+1)'(a_par) - (CW+1)'(quot)
                           : (CW+1)'(a_par) + (CW+1)'(quot);
    p_par  = p_par_wide[CW-1:0];
    p_perp = edge_pos[CW-1:0];

    unique case (sidx_q)
      2'd0:    p_sel = ax_q;
      2'd1:    p_sel = ay_q;
      2'd2:    p_sel = bx_q;
      default: p_sel = by_q;
    endcase
    shift_sel = sidx_q[0] ? shift_y_q : shift_x_q;
    mag_p = p_sel[CW-1] ? MW'(-p_sel) : MW'(p_sel);

    scaling = (state_q == SScaleMul) || (state_q == SScaleAdd);
    opa = scaling ? mag_p : mag_d0;
    opb = scaling ? MW'(zoom_q) : mag_delta;
    cmd.mul = (state_q == SMul) || (state_q == SScaleMul);
    cmd.div = (state_q == SDivStart);

    sprod = p_sel[CW-1] ? -SW'(prod) : SW'(prod);
    rnd = RW'(sprod) + RoundBias;
    scaled = (rnd >>> ZoomFracBits) + (RW'(shift_sel) <<< FRACTION_BITS);
    if (scaled > SatHi) begin
      sat_val = 32'sh7fffffff;
    end else if (scaled < SatLo) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = scaled[31:0];
    end
  end

  prc_muldiv #(
    .MagWidth(MW)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .den_i  (den),
    .prod_o (prod),
    .quot_o (quot),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_width_q  <= '0;
      clip_height_q <= '0;
      shift_x_q     <= '0;
      shift_y_q     <= '0;
      zoom_q        <= ZoomReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgClipLeft:   clip_left_q   <= cfg_wdata_i;
        CfgClipTop:    clip_top_q    <= cfg_wdata_i;
        CfgClipWidth:  clip_width_q  <= cfg_wdata_i;
        CfgClipHeight: clip_height_q <= cfg_wdata_i;
        CfgShiftX:     shift_x_q     <= cfg_wdata_i;
        CfgShiftY:     shift_y_q     <= cfg_wdata_i;
        CfgZoom:       zoom_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      edge_q        <= EdgeLeft;
      sidx_q        <= '0;
      prior_x_q     <= '0;
      prior_y_q     <= '0;
      prior_valid_q <= 1'b0;
      ax_q          <= '0;
      ay_q          <= '0;
      bx_q          <= '0;
      by_q          <= '0;
      res_q         <= '{default: '0};
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != SPush)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            prior_x_q     <= in_word_i.vertex_x;
            prior_y_q     <= in_word_i.vertex_y;
            prior_valid_q <= 1'b1;
            if (!in_word_i.new_line && prior_valid_q) begin
              ax_q    <= {prior_x_q, 1'b1, {(FRACTION_BITS-1){1'b0}}};
              ay_q    <= {prior_y_q, 1'b1, {(FRACTION_BITS-1){1'b0}}};
              bx_q    <= {in_word_i.vertex_x, 1'b1, {(FRACTION_BITS-1){1'b0}}};
              by_q    <= {in_word_i.vertex_y, 1'b1, {(FRACTION_BITS-1){1'b0}}};
              edge_q  <= EdgeLeft;
              state_q <= SEdge;
            end
          end
        end
        SEdge: begin
          if (drop) begin
            state_q <= SIdle;
          end else if (pass) begin
            if (edge_q == EdgeBottom) begin
              sidx_q  <= '0;
              state_q <= SScaleMul;
            end else begin
              edge_q <= edge_e'(edge_q + 2'd1);
            end
          end else begin
            state_q <= SMul;
          end
        end
        SMul: begin
          state_q <= SDivStart;
        end
        SDivStart: begin
          state_q <= SDivWait;
        end
        SDivWait: begin
          if (div_done) begin
            state_q <= SFix;
          end
        end
        SFix: begin
          if (d0_pos) begin
            if (edge_is_x) begin
              bx_q <= p_perp;
              by_q <= p_par;
            end else begin
              bx_q <= p_par;
              by_q <= p_perp;
            end
          end else begin
            if (edge_is_x) begin
              ax_q <= p_perp;
              ay_q <= p_par;
            end else begin
              ax_q <= p_par;
              ay_q <= p_perp;
            end
          end
          if (edge_q == EdgeBottom) begin
            sidx_q  <= '0;
            state_q <= SScaleMul;
          end else begin
            edge_q  <= edge_e'(edge_q + 2'd1);
            state_q <= SEdge;
          end
        end
        SScaleMul: begin
          state_q <= SScaleAdd;
        end
        SScaleAdd: begin
          res_q[sidx_q] <= sat_val;
          if (sidx_q == 2'd3) begin
            state_q <= SPush;
          end else begin
            sidx_q  <= sidx_q + 2'd1;
            state_q <= SScaleMul;
          end
        end
        SPush: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.start_x <= res_q[0];
            out_q.start_y <= res_q[1];
            out_q.end_x   <= res_q[2];
            out_q.end_y   <= res_q[3];
            out_valid_q   <= 1'b1;
            state_q       <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A new word appears only when a finished segment is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == SPush))
    else $error("output word raised outside the load step");
  // The intersection stays between the two endpoints.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFix |-> quot <= mag_delta)
    else $error("intersection quotient exceeds the segment extent");
  // Segment work only starts once a previous vertex exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> prior_valid_q)
    else $error("segment processed without a previous vertex");

endmodule
